[rtl/core/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-timestep frame clock package
// Shared widths, codes, reset values, item types and control structs.
// ----------------------------------------------------------------------------
package fsc_pkg;

	// default parameter values
	localparam int unsigned MAX_QUEUED_STEPS_DEF = 1000;
	localparam int unsigned TIME_BITS_DEF        = 40;

	// field widths
	localparam int unsigned FD_W      = 30;
	localparam int unsigned SCALE_W   = 23;
	localparam int unsigned MFD_W     = 32;
	localparam int unsigned CAP_W     = 16;
	localparam int unsigned DELTA_W   = 40;
	localparam int unsigned USED_W    = 32;
	localparam int unsigned SCALED_W  = 39;
	localparam int unsigned ALPHA_W   = 17;
	localparam int unsigned FRAME_W   = 32;
	localparam int unsigned TOTAL_W   = 64;
	localparam int unsigned REQ_W     = 32;
	localparam int unsigned MUL_A_W   = 32;
	localparam int unsigned MUL_P_W   = MUL_A_W + FD_W;
	localparam int unsigned CAPMUL_W  = CAP_W + FD_W;
	localparam int unsigned Q16_SHIFT = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 32;

	// command codes
	localparam logic [1:0] CMD_ADVANCE = 2'd0;
	localparam logic [1:0] CMD_QUEUE   = 2'd1;
	localparam logic [1:0] CMD_PAUSE   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DELTA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 2'd3;

	// configuration reset values
	localparam logic [FD_W-1:0]    RST_FIXED_DELTA = 30'd16666667;
	localparam logic [SCALE_W-1:0] RST_TIME_SCALE  = 23'd65536;
	localparam logic [MFD_W-1:0]   RST_MAX_DELTA   = 32'd250000000;
	localparam logic [CAP_W-1:0]   RST_MAX_STEPS   = 16'd5;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	// one command word
	typedef struct packed {
		logic [1:0]                command;
		logic signed [DELTA_W-1:0] real_delta_ns;
		logic [REQ_W-1:0]          step_request;
		logic                      pause_value;
	} cmd_item_t;

	// one result word
	typedef struct packed {
		logic [FRAME_W-1:0]  frame_number;
		logic [USED_W-1:0]   real_delta_used;
		logic [SCALED_W-1:0] scaled_delta;
		logic [CAP_W-1:0]    fixed_steps;
		logic [ALPHA_W-1:0]  alpha_q16;
		logic                is_paused;
		logic                was_stepped;
		logic [TOTAL_W-1:0]  total_fixed_steps;
		logic [TOTAL_W-1:0]  simulated_time;
		logic [TOTAL_W-1:0]  dropped_time;
	} res_item_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIVS,
		ST_PROD,
		ST_DIFF,
		ST_CAP,
		ST_AGO,
		ST_DIVA,
		ST_DONE
	} state_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic adv_run;
		logic adv_step;
		logic adv_hold;
		logic div_done;
		logic acc_ge_fd;
		logic out_free;
	} sts_t;

	// sequencer controls to the datapath
	typedef struct packed {
		logic busy;
		logic ld_scaled;
		logic div_steps;
		logic sel_cap;
		logic ld_capmul;
		logic ld_drop;
		logic apply;
		logic div_alpha;
		logic alpha_full;
		logic ld_alpha_div;
		logic ld_out;
	} ctl_t;

endpackage

[rtl/core/fixed_timestep_frame_clock.sv]
// ----------------------------------------------------------------------------
// Fixed-timestep frame clock
// Nanosecond fixed-point frame clock: clamps the frame delta, scales it,
// accumulates it and splits it into capped fixed steps plus a Q1.16 alpha.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            word
//  cmd      in         cmd_valid/cmd_stall  cmd_item_t
//  res      out        res_valid/res_stall  res_item_t
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Queue and pause commands give no result and do not stall cmd.
//  A running advance stalls cmd through multiply, bit-serial step division,
//  cap and, if the remainder is below the fixed delta, bit-serial alpha division.
//  A paused advance skips to output with a queued step, else computes alpha.
//  cmd_stall is high while an advance is in work; a finished result waits
//  in the output register, so the next command is taken meanwhile.
//  Reset clears all counters and totals and loads the register defaults.
// ----------------------------------------------------------------------------
module fixed_timestep_frame_clock #(
	parameter int unsigned MAX_QUEUED_STEPS = fsc_pkg::MAX_QUEUED_STEPS_DEF,
	parameter int unsigned TIME_BITS        = fsc_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  fsc_pkg::cmd_item_t              cmd,
	output logic                            res_valid,
	input  logic                            res_stall,
	output fsc_pkg::res_item_t              res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsc_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import fsc_pkg::*;

	localparam int unsigned QW    = $clog2(MAX_QUEUED_STEPS + 1);
	localparam int unsigned SUM_W = ((TIME_BITS > SCALED_W) ? TIME_BITS : SCALED_W) + 1;
	localparam int unsigned DW    = (TIME_BITS > CAPMUL_W) ? TIME_BITS : CAPMUL_W;
	localparam int unsigned QS_W  = REQ_W + 1;

	// configuration registers
	logic [FD_W-1:0]    fd_q;
	logic [SCALE_W-1:0] scale_q;
	logic [MFD_W-1:0]   mfd_q;
	logic [CAP_W-1:0]   cap_q;

	// architectural state
	logic [FRAME_W-1:0]   frame_q;
	logic                 paused_q;
	logic [QW-1:0]        queued_q;
	logic [TIME_BITS-1:0] time_acc_q;
	logic [TOTAL_W-1:0]   sim_total_q;
	logic [TOTAL_W-1:0]   drop_total_q;
	logic [TOTAL_W-1:0]   step_total_q;

	// per-frame work registers
	logic [USED_W-1:0]    used_q;
	logic [SCALED_W-1:0]  scaled_q;
	logic [CAP_W-1:0]     steps_q;
	logic [ALPHA_W-1:0]   alpha_q;
	logic                 stepped_q;
	logic [CAPMUL_W-1:0]  capmul_q;
	logic [TIME_BITS-1:0] acc_q;
	logic [TIME_BITS-1:0] drop_q;

	// output register
	logic      res_valid_q;
	res_item_t res_q;

	ctl_t ctl;
	sts_t sts;

	logic                 cmd_acc;
	logic                 adv;
	logic [FD_W-1:0]      fd_eff;
	logic [USED_W-1:0]    used_d;
	logic [QS_W-1:0]      q_sum;
	logic [QW-1:0]        q_new;
	logic [MUL_A_W-1:0]   mul_a;
	logic [FD_W-1:0]      mul_b;
	logic [MUL_P_W-1:0]   prod;
	logic [SUM_W-1:0]     acc_sum;
	logic [TIME_BITS-1:0] acc_sat;
	logic [DW-1:0]        drop_d;
	logic                 div_done;
	logic [TIME_BITS-1:0] div_quot;
	logic [FD_W-1:0]      div_rem;
	logic                 over;
	logic [CAP_W-1:0]     steps_new;

	// input side
	assign cmd_stall = ctl.busy;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign adv       = cmd_acc && (cmd.command == CMD_ADVANCE);
	assign fd_eff    = (fd_q == '0) ? FD_W'(1) : fd_q;
	assign cfg_ready = 1'b1;

	// delta clamp
	always_comb begin
		if (cmd.real_delta_ns[DELTA_W-1]) begin
			used_d = '0;
		end else if (cmd.real_delta_ns < $signed({8'd0, mfd_q})) begin
			used_d = cmd.real_delta_ns[USED_W-1:0];
		end else begin
			used_d = mfd_q;
		end
	end

	// single-step queue add, saturating
	always_comb begin
		q_sum = QS_W'(queued_q) + QS_W'(cmd.step_request);
		q_new = (q_sum > QS_W'(MAX_QUEUED_STEPS)) ? QW'(MAX_QUEUED_STEPS) : q_sum[QW-1:0];
	end

	// shared multiplier: delta times scale, then cap times fixed delta
	always_comb begin
		mul_a = ctl.sel_cap ? MUL_A_W'(cap_q) : used_q;
		mul_b = ctl.sel_cap ? fd_eff : FD_W'(scale_q);
		prod  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

	// accumulator add with saturation
	always_comb begin
		acc_sum = SUM_W'(time_acc_q) + SUM_W'(scaled_q);
		acc_sat = (|acc_sum[SUM_W-1:TIME_BITS]) ? '1 : acc_sum[TIME_BITS-1:0];
		drop_d  = DW'(acc_q) - DW'(capmul_q);
	end

	// step cap decision
	always_comb begin
		over      = div_quot > TIME_BITS'(cap_q);
		steps_new = over ? cap_q : div_quot[CAP_W-1:0];
	end

	fsc_div #(
		.TIME_BITS (TIME_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (ctl.div_steps | ctl.div_alpha),
		.alpha_mode (ctl.div_alpha),
		.dividend   (acc_sat),
		.rem_init   (time_acc_q[FD_W-1:0]),
		.divisor    (fd_eff),
		.done       (div_done),
		.quot       (div_quot),
		.rem        (div_rem)
	);

	// status to the sequencer
	always_comb begin
		sts.adv_run   = adv && !paused_q;
		sts.adv_step  = adv && paused_q && (queued_q != '0);
		sts.adv_hold  = adv && paused_q && (queued_q == '0);
		sts.div_done  = div_done;
		sts.acc_ge_fd = (time_acc_q >= TIME_BITS'(fd_eff));
		sts.out_free  = !res_valid_q || !res_stall;
	end

	fsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_q    <= RST_FIXED_DELTA;
			scale_q <= RST_TIME_SCALE;
			mfd_q   <= RST_MAX_DELTA;
			cap_q   <= RST_MAX_STEPS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIXED_DELTA: fd_q    <= cfg_data[FD_W-1:0];
				CFG_TIME_SCALE:  scale_q <= cfg_data[SCALE_W-1:0];
				CFG_MAX_DELTA:   mfd_q   <= cfg_data[MFD_W-1:0];
				CFG_MAX_STEPS:   cap_q   <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clock state: commands, step release and cap application
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q      <= '0;
			paused_q     <= 1'b0;
			queued_q     <= '0;
			time_acc_q   <= '0;
			sim_total_q  <= '0;
			drop_total_q <= '0;
			step_total_q <= '0;
		end else begin
			if (cmd_acc) begin
				case (cmd.command)
					CMD_QUEUE: begin
						if (paused_q) begin
							queued_q <= q_new;
						end
					end
					CMD_PAUSE: begin
						paused_q <= cmd.pause_value;
						if (!cmd.pause_value) begin
							queued_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (adv) begin
				frame_q <= frame_q + FRAME_W'(1);
			end
			if (sts.adv_step) begin
				queued_q     <= queued_q - QW'(1);
				sim_total_q  <= sim_total_q + TOTAL_W'(fd_eff);
				step_total_q <= step_total_q + TOTAL_W'(1);
			end
			if (ctl.apply) begin
				time_acc_q   <= over ? '0 : TIME_BITS'(div_rem);
				step_total_q <= step_total_q + TOTAL_W'(steps_new);
				sim_total_q  <= sim_total_q + TOTAL_W'(scaled_q);
				if (over) begin
					drop_total_q <= drop_total_q + TOTAL_W'(drop_q);
				end
			end
		end
	end

	// per-frame work registers
	always_ff @(posedge clk) begin
		if (adv) begin
			used_q    <= used_d;
			stepped_q <= sts.adv_step;
			if (sts.adv_step) begin
				scaled_q <= SCALED_W'(fd_eff);
				steps_q  <= CAP_W'(1);
				alpha_q  <= ALPHA_ONE;
			end else begin
				scaled_q <= '0;
				steps_q  <= '0;
			end
		end
		if (ctl.ld_scaled) begin
			scaled_q <= prod[Q16_SHIFT +: SCALED_W];
		end
		if (ctl.div_steps) begin
			acc_q <= acc_sat;
		end
		if (ctl.ld_capmul) begin
			capmul_q <= prod[CAPMUL_W-1:0];
		end
		if (ctl.ld_drop) begin
			drop_q <= drop_d[TIME_BITS-1:0];
		end
		if (ctl.apply) begin
			steps_q <= steps_new;
		end
		if (ctl.alpha_full) begin
			alpha_q <= ALPHA_ONE;
		end
		if (ctl.ld_alpha_div) begin
			alpha_q <= ALPHA_W'(div_quot[Q16_SHIFT-1:0]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.ld_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			res_q.frame_number      <= frame_q;
			res_q.real_delta_used   <= used_q;
			res_q.scaled_delta      <= scaled_q;
			res_q.fixed_steps       <= steps_q;
			res_q.alpha_q16         <= alpha_q;
			res_q.is_paused         <= paused_q;
			res_q.was_stepped       <= stepped_q;
			res_q.total_fixed_steps <= step_total_q;
			res_q.simulated_time    <= sim_total_q;
			res_q.dropped_time      <= drop_total_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/fsc_div.sv]
// ----------------------------------------------------------------------------
// Fixed-timestep frame clock divider
// Restoring divider, one quotient bit per cycle. Step mode divides the full
// accumulator; alpha mode runs 16 bits from a preloaded remainder.
// ----------------------------------------------------------------------------
module fsc_div #(
	parameter int unsigned TIME_BITS = fsc_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       alpha_mode,
	input  logic [TIME_BITS-1:0]       dividend,
	input  logic [fsc_pkg::FD_W-1:0]   rem_init,
	input  logic [fsc_pkg::FD_W-1:0]   divisor,
	output logic                       done,
	output logic [TIME_BITS-1:0]       quot,
	output logic [fsc_pkg::FD_W-1:0]   rem
);
	import fsc_pkg::*;

	localparam int unsigned CW = $clog2(TIME_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [TIME_BITS-1:0] dvd_q;
	logic [TIME_BITS-1:0] quot_q;
	logic [FD_W-1:0]      rem_q;
	logic [FD_W:0]        trial;
	logic [FD_W:0]        diff;
	logic                 ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, dvd_q[TIME_BITS-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= alpha_mode ? CW'(Q16_SHIFT) : CW'(TIME_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= alpha_mode ? '0 : dividend;
			rem_q <= alpha_mode ? rem_init : '0;
		end else if (busy_q) begin
			dvd_q  <= dvd_q << 1;
			rem_q  <= ge ? diff[FD_W-1:0] : trial[FD_W-1:0];
			quot_q <= {quot_q[TIME_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

[rtl/core/fsc_ctrl.sv]
// ----------------------------------------------------------------------------
// Fixed-timestep frame clock sequencer
// Steps a running advance through multiply, accumulate, divide, cap and
// alpha, a paused one at most through alpha; then loads the output register.
// ----------------------------------------------------------------------------
module fsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  fsc_pkg::sts_t sts,
	output fsc_pkg::ctl_t ctl
);
	import fsc_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (sts.adv_run) begin
					state_d = ST_MUL;
				end else if (sts.adv_step) begin
					state_d = ST_DONE;
				end else if (sts.adv_hold) begin
					state_d = ST_AGO;
				end
			end
			ST_MUL: begin
				ctl.ld_scaled = 1'b1;
				state_d       = ST_SUM;
			end
			ST_SUM: begin
				ctl.div_steps = 1'b1;
				state_d       = ST_DIVS;
			end
			ST_DIVS: begin
				if (sts.div_done) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				ctl.sel_cap   = 1'b1;
				ctl.ld_capmul = 1'b1;
				state_d       = ST_DIFF;
			end
			ST_DIFF: begin
				ctl.ld_drop = 1'b1;
				state_d     = ST_CAP;
			end
			ST_CAP: begin
				ctl.apply = 1'b1;
				state_d   = ST_AGO;
			end
			ST_AGO: begin
				if (sts.acc_ge_fd) begin
					ctl.alpha_full = 1'b1;
					state_d        = ST_DONE;
				end else begin
					ctl.div_alpha = 1'b1;
					state_d       = ST_DIVA;
				end
			end
			ST_DIVA: begin
				if (sts.div_done) begin
					ctl.ld_alpha_div = 1'b1;
					state_d          = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[tb/frame_clock_checker.sv]
// ----------------------------------------------------------------------------
// Frame clock checker
// Watches the command, result and register channels of the frame clock.
// Keeps its own copy of the clock state and registers, predicts one result
// word per advance and compares every result word field by field.
// ----------------------------------------------------------------------------
module frame_clock_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  logic                          cmd_stall,
	input  fsc_pkg::cmd_item_t            cmd,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  fsc_pkg::res_item_t            res,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsc_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          drain_done,
	output int                            errors,
	output int                            pending
);
	import fsc_pkg::*;

	localparam logic [63:0] ACC_LIMIT   = (64'd1 << TIME_BITS_DEF) - 64'd1;
	localparam logic [63:0] QUEUE_LIMIT = 64'(MAX_QUEUED_STEPS_DEF);

	// register copies
	logic [FD_W-1:0]    fixed_delta;
	logic [SCALE_W-1:0] time_scale;
	logic [MFD_W-1:0]   max_delta;
	logic [CAP_W-1:0]   max_steps;

	// clock state
	logic [FRAME_W-1:0] frame_cnt;
	logic               paused;
	logic [63:0]        queued;
	logic [63:0]        accum;
	logic [63:0]        sim_total;
	logic [63:0]        drop_total;
	logic [63:0]        step_total;
	logic               drained;

	res_item_t expected_frames[$];

	initial errors = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want, input logic [FRAME_W-1:0] frame);
		if (got !== want)
			report_mismatch($sformatf("frame %0d %s: got %0d, expected %0d",
				frame, name, got, want));
	endtask

	// alpha = accumulator / fixed delta in Q1.16, clamped to one
	function automatic logic [ALPHA_W-1:0] alpha_fraction(input logic [63:0] acc,
			input logic [63:0] fd);
		logic [63:0] q;
		q = (acc << Q16_SHIFT) / fd;
		return (q > 64'(ALPHA_ONE)) ? ALPHA_ONE : q[ALPHA_W-1:0];
	endfunction

	// apply one command word to the clock state, queue the frame it yields
	task automatic step_clock(input cmd_item_t w);
		logic [63:0] fd;
		logic [63:0] used;
		logic [63:0] scaled;
		logic [63:0] steps;
		logic [63:0] acc;
		logic [ALPHA_W-1:0] alpha;
		logic stepped;
		res_item_t r;
		fd = (fixed_delta == '0) ? 64'd1 : 64'(fixed_delta);
		case (w.command)
		CMD_QUEUE: begin
			if (paused) begin
				queued = queued + 64'(w.step_request);
				if (queued > QUEUE_LIMIT)
					queued = QUEUE_LIMIT;
			end
		end
		CMD_PAUSE: begin
			paused = w.pause_value;
			if (!paused)
				queued = '0;
		end
		CMD_ADVANCE: begin
			scaled = '0;
			steps = '0;
			stepped = 1'b0;
			frame_cnt = frame_cnt + 1'b1;
			// negative delta counts as zero, large delta is clamped
			if (w.real_delta_ns[DELTA_W-1])
				used = '0;
			else if ({24'd0, w.real_delta_ns} < 64'(max_delta))
				used = {24'd0, w.real_delta_ns};
			else
				used = 64'(max_delta);
			if (paused) begin
				if (queued != '0) begin
					queued = queued - 64'd1;
					stepped = 1'b1;
					steps = 64'd1;
					scaled = fd;
					alpha = ALPHA_ONE;
					sim_total = sim_total + fd;
					step_total = step_total + 64'd1;
				end else begin
					alpha = alpha_fraction(accum, fd);
				end
			end else begin
				scaled = (used * 64'(time_scale)) >> Q16_SHIFT;
				acc = accum + scaled;
				if (acc > ACC_LIMIT)
					acc = ACC_LIMIT;
				steps = acc / fd;
				// step cap: drop the rest of the frame
				if (steps > 64'(max_steps)) begin
					drop_total = drop_total + (acc - 64'(max_steps) * fd);
					steps = 64'(max_steps);
					acc = '0;
				end else begin
					acc = acc - steps * fd;
				end
				accum = acc;
				alpha = alpha_fraction(acc, fd);
				step_total = step_total + steps;
				sim_total = sim_total + scaled;
			end
			r.frame_number = frame_cnt;
			r.real_delta_used = used[USED_W-1:0];
			r.scaled_delta = scaled[SCALED_W-1:0];
			r.fixed_steps = steps[CAP_W-1:0];
			r.alpha_q16 = alpha;
			r.is_paused = paused;
			r.was_stepped = stepped;
			r.total_fixed_steps = step_total;
			r.simulated_time = sim_total;
			r.dropped_time = drop_total;
			expected_frames.push_back(r);
		end
		default: ;
		endcase
	endtask

	task automatic check_frame(input res_item_t got);
		res_item_t want;
		if (expected_frames.size() == 0) begin
			report_mismatch($sformatf("result word for frame %0d with nothing pending",
				got.frame_number));
			return;
		end
		want = expected_frames.pop_front();
		compare_field("frame_number", 64'(got.frame_number), 64'(want.frame_number),
			want.frame_number);
		compare_field("real_delta_used", 64'(got.real_delta_used),
			64'(want.real_delta_used), want.frame_number);
		compare_field("scaled_delta", 64'(got.scaled_delta), 64'(want.scaled_delta),
			want.frame_number);
		compare_field("fixed_steps", 64'(got.fixed_steps), 64'(want.fixed_steps),
			want.frame_number);
		compare_field("alpha_q16", 64'(got.alpha_q16), 64'(want.alpha_q16),
			want.frame_number);
		compare_field("is_paused", 64'(got.is_paused), 64'(want.is_paused),
			want.frame_number);
		compare_field("was_stepped", 64'(got.was_stepped), 64'(want.was_stepped),
			want.frame_number);
		compare_field("total_fixed_steps", got.total_fixed_steps,
			want.total_fixed_steps, want.frame_number);
		compare_field("simulated_time", got.simulated_time, want.simulated_time,
			want.frame_number);
		compare_field("dropped_time", got.dropped_time, want.dropped_time,
			want.frame_number);
	endtask

	// result first, so a word can never pair with a command taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_delta = RST_FIXED_DELTA;
			time_scale = RST_TIME_SCALE;
			max_delta = RST_MAX_DELTA;
			max_steps = RST_MAX_STEPS;
			frame_cnt = '0;
			paused = 1'b0;
			queued = '0;
			accum = '0;
			sim_total = '0;
			drop_total = '0;
			step_total = '0;
			drained = 1'b0;
			expected_frames.delete();
		end else begin
			if (res_valid && !res_stall)
				check_frame(res);
			if (cmd_valid && !cmd_stall)
				step_clock(cmd);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_FIXED_DELTA: fixed_delta = cfg_data[FD_W-1:0];
				CFG_TIME_SCALE:  time_scale = cfg_data[SCALE_W-1:0];
				CFG_MAX_DELTA:   max_delta = cfg_data[MFD_W-1:0];
				CFG_MAX_STEPS:   max_steps = cfg_data[CAP_W-1:0];
				default: ;
				endcase
			end
			// frames still owed once the run has drained
			if (drain_done && !drained) begin
				drained = 1'b1;
				foreach (expected_frames[i])
					report_mismatch($sformatf("frame %0d never came out",
						expected_frames[i].frame_number));
			end
		end
		pending = expected_frames.size();
	end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Frame clock testbench
// Drives directed and random command words into the fixed-timestep frame
// clock across several register settings and traffic patterns; the checker
// beside the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import fsc_pkg::*;

	localparam int unsigned IDLE_LIMIT    = 5000;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_WORDS   = 130;
	localparam int unsigned PHASES        = 5;
	localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;

	typedef enum logic [1:0] {
		TRAFFIC_FREE,
		TRAFFIC_SEND_GAPS,
		TRAFFIC_RECV_STALLS,
		TRAFFIC_BOTH
	} traffic_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_item_t            cmd = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_item_t            res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 drain_done = 1'b0;
	int                   errors;
	int                   pending;

	traffic_t    traffic = TRAFFIC_FREE;
	int unsigned hold_request = 0;
	int unsigned idle_cycles = 0;
	logic [63:0] cur_fd = 64'(RST_FIXED_DELTA);
	logic [63:0] cur_maxd = 64'(RST_MAX_DELTA);

	fixed_timestep_frame_clock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frame_clock_checker frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.drain_done (drain_done),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit chance(input int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic cmd_item_t make_word(input logic [1:0] code,
			input logic [DELTA_W-1:0] delta, input logic [REQ_W-1:0] count,
			input logic pause);
		cmd_item_t w;
		w.command = code;
		w.real_delta_ns = delta;
		w.step_request = count;
		w.pause_value = pause;
		return w;
	endfunction

	// mostly advances with deltas shaped around the current registers
	function automatic cmd_item_t random_word();
		cmd_item_t w;
		logic [63:0] r;
		int unsigned pick;
		int unsigned sel;
		r = {$urandom, $urandom};
		w = make_word(CMD_ADVANCE, r[DELTA_W-1:0], $urandom, 1'($urandom_range(1)));
		pick = $urandom_range(99);
		sel = $urandom_range(99);
		if (pick < 70) begin
			if (sel < 35)
				w.real_delta_ns = DELTA_W'(r % (cur_maxd + 64'd1));
			else if (sel < 60)
				w.real_delta_ns = DELTA_W'(r % (64'd2 * cur_fd + 64'd1));
			else if (sel < 70)
				w.real_delta_ns = DELTA_W'(cur_maxd + 64'($urandom_range(1)));
			else if (sel < 80)
				w.real_delta_ns = '0;
			else if (sel < 90)
				w.real_delta_ns = {1'b1, r[DELTA_W-2:0]};
		end else if (pick < 80) begin
			w.command = CMD_QUEUE;
			if (sel < 70)
				w.step_request = $urandom_range(4);
		end else if (pick < 95) begin
			w.command = CMD_PAUSE;
		end else begin
			w.command = CMD_UNKNOWN;
		end
		return w;
	endfunction

	// offer one word after a random gap, hold it until taken
	task automatic send_word(input cmd_item_t w);
		int unsigned gap_pct;
		gap_pct = (traffic == TRAFFIC_SEND_GAPS) ? 62 : (traffic == TRAFFIC_BOTH) ? 25 : 0;
		while (chance(gap_pct)) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		@(negedge clk);
		while (cmd_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	// stop offering and let every frame drain before touching registers
	task automatic settle();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic load_clock_config(input logic [31:0] fd, input logic [31:0] scale,
			input logic [31:0] maxd, input logic [31:0] cap);
		put_reg(CFG_FIXED_DELTA, fd);
		put_reg(CFG_TIME_SCALE, scale);
		put_reg(CFG_MAX_DELTA, maxd);
		put_reg(CFG_MAX_STEPS, cap);
		cfg_valid <= 1'b0;
		cur_fd = (fd[FD_W-1:0] == '0) ? 64'd1 : 64'(fd[FD_W-1:0]);
		cur_maxd = 64'(maxd);
	endtask

	// receiver: random stalls, or one long hold when asked
	initial begin
		int unsigned held;
		int unsigned stall_pct;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				held = hold_request;
				hold_request = 0;
			end
			stall_pct = (traffic == TRAFFIC_RECV_STALLS) ? 62 :
				(traffic == TRAFFIC_BOTH) ? 25 : 0;
			if (held != 0) begin
				res_stall <= 1'b1;
				held--;
			end else begin
				res_stall <= chance(stall_pct);
			end
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: clamps, cap drop, queue and pause handling
		send_word(make_word(CMD_ADVANCE, 40'd0, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd16666667, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'hFF_FFFF_FFFF, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'h80_0000_0000, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'h7F_FFFF_FFFF, '0, 1'b0));
		send_word(make_word(CMD_QUEUE, '0, 32'd5, 1'b0));
		send_word(make_word(CMD_UNKNOWN, 40'd1000, 32'd3, 1'b1));
		send_word(make_word(CMD_PAUSE, '0, '0, 1'b1));
		send_word(make_word(CMD_ADVANCE, 40'd10000000, '0, 1'b0));
		send_word(make_word(CMD_QUEUE, '0, 32'd2, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd5000000, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd5000000, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd5000000, '0, 1'b0));
		send_word(make_word(CMD_QUEUE, '0, 32'hFFFF_FFFF, 1'b0));
		send_word(make_word(CMD_QUEUE, '0, 32'd7, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd1, '0, 1'b0));
		send_word(make_word(CMD_PAUSE, '0, '0, 1'b0));
		send_word(make_word(CMD_PAUSE, '0, '0, 1'b1));
		send_word(make_word(CMD_ADVANCE, 40'd1, '0, 1'b0));
		send_word(make_word(CMD_PAUSE, '0, '0, 1'b0));

		// zero fixed delta, full scale, widest delta, zero step cap
		settle();
		load_clock_config(32'd0, 32'h7F_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_word(make_word(CMD_ADVANCE, 40'h7F_FFFF_FFFF, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd1, '0, 1'b0));

		// longest fixed delta, zero scale, one-ns delta limit, widest cap
		settle();
		load_clock_config(32'h3FFF_FFFF, 32'd0, 32'd1, 32'hFFFF);
		send_word(make_word(CMD_ADVANCE, 40'd5, '0, 1'b0));

		// one-ms step, full scale, widest cap: heavy cap drops
		settle();
		load_clock_config(32'd1000000, 32'h7F_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
		send_word(make_word(CMD_ADVANCE, 40'hFF_FFFF_FFFF >> 8, '0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 40'd123456, '0, 1'b0));

		// random phases, one register setting and traffic pattern each
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
			0: begin
				traffic = TRAFFIC_FREE;
				load_clock_config(32'(RST_FIXED_DELTA), 32'(RST_TIME_SCALE),
					32'(RST_MAX_DELTA), 32'(RST_MAX_STEPS));
			end
			1: begin
				traffic = TRAFFIC_SEND_GAPS;
				load_clock_config(32'd1000000, 32'd6553600, 32'd1000000000, 32'd65535);
			end
			2: begin
				traffic = TRAFFIC_RECV_STALLS;
				load_clock_config(32'd1000000000, 32'd6553600, 32'hFFFF_FFFF, 32'd1);
			end
			3: begin
				traffic = TRAFFIC_BOTH;
				load_clock_config($urandom_range(1000000000, 1000000),
					$urandom_range(6553600), $urandom_range(32'hFFFF_FFFF, 1),
					$urandom_range(8, 1));
			end
			default: begin
				traffic = TRAFFIC_BOTH;
				load_clock_config($urandom, $urandom, $urandom, $urandom);
			end
			endcase
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// the sender waits out every pending frame once
				if (phase == 1 && i == 65) begin
					cmd_valid <= 1'b0;
					@(negedge clk);
					while (pending != 0)
						@(negedge clk);
					@(posedge clk);
				end
				// the receiver holds off while words keep coming
				if (phase == 2 && i == 40)
					hold_request = HOLD_CYCLES;
				send_word(random_word());
			end
		end

		settle();
		drain_done <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/fsc_pkg.sv
rtl/core/fsc_div.sv
rtl/core/fsc_ctrl.sv
rtl/core/fixed_timestep_frame_clock.sv
tb/frame_clock_checker.sv
tb/tb.sv
